/* hw/rtl/ant_pkg.sv */
// Shared constants and widths for the adaptive noise threshold block.
`default_nettype none

package ant_pkg;

  // Storage and data widths.
  localparam int LEVEL_WIDTH = 16;
  localparam int MAX_HISTORY = 128;
  localparam int MIN_LENGTH  = 10;

  // Register field widths.
  localparam int HIST_WIDTH  = 8;
  localparam int SIGMA_WIDTH = 12;
  localparam int CFG_WIDTH   = 16;
  localparam int IDX_WIDTH   = 2;

  // Register indexes on the configuration port.
  localparam logic [IDX_WIDTH-1:0] REG_HISTORY_LENGTH = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_ONSET_SIGMA    = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_SILENCE_SIGMA  = 2'd2;
  localparam logic [IDX_WIDTH-1:0] REG_MIN_STD_DEV    = 2'd3;

  // Derived widths.
  localparam int POS_WIDTH   = $clog2(MAX_HISTORY);
  localparam int CNT_WIDTH   = $clog2(MAX_HISTORY + 1);
  localparam int SUM_WIDTH   = LEVEL_WIDTH + CNT_WIDTH;
  localparam int SQ_WIDTH    = 2 * LEVEL_WIDTH;
  localparam int VSUM_WIDTH  = SQ_WIDTH + CNT_WIDTH;
  localparam int MS_WIDTH    = LEVEL_WIDTH + SUM_WIDTH;
  localparam int DIV_WIDTH   = (VSUM_WIDTH > MS_WIDTH) ? VSUM_WIDTH : MS_WIDTH;
  localparam int PROD_WIDTH  = SIGMA_WIDTH + LEVEL_WIDTH;
  localparam int THR_WIDTH   = PROD_WIDTH + 2;
  localparam int FRAC_BITS   = 8;

  // Reset values of the registers.
  localparam logic [HIST_WIDTH-1:0]  HISTORY_LENGTH_RESET = 8'd94;
  localparam logic [SIGMA_WIDTH-1:0] ONSET_SIGMA_RESET    = 12'd768;
  localparam logic [SIGMA_WIDTH-1:0] SILENCE_SIGMA_RESET  = 12'd384;
  localparam logic [LEVEL_WIDTH-1:0] MIN_STD_DEV_RESET    = 16'd7;

endpackage

`default_nettype wire

/* hw/rtl/ant_div.sv */
// Bit-serial restoring divider: wide dividend by a short count.
`default_nettype none

module ant_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ant_pkg::DIV_WIDTH-1:0] dividend,
  input  logic [ant_pkg::CNT_WIDTH-1:0] divisor,
  output logic                          done,
  output logic [ant_pkg::DIV_WIDTH-1:0] quotient
);
  import ant_pkg::*;

  localparam int STEP_WIDTH = $clog2(DIV_WIDTH + 1);

  logic [DIV_WIDTH-1:0]  quo;
  logic [CNT_WIDTH-1:0]  rem;
  logic [STEP_WIDTH-1:0] steps;
  logic                  busy;
  logic [CNT_WIDTH:0]    trial;
  logic [CNT_WIDTH:0]    diff;
  logic                  fits;

  // One quotient bit per cycle: bring down the next dividend bit and try the divisor.
  always_comb begin
    trial = {rem, quo[DIV_WIDTH-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_WIDTH'(DIV_WIDTH);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIV_WIDTH-2:0], fits};
      rem <= fits ? diff[CNT_WIDTH-1:0] : trial[CNT_WIDTH-1:0];
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* hw/rtl/ant_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module ant_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ant_pkg::SQ_WIDTH-1:0]    radicand,
  output logic                            done,
  output logic [ant_pkg::LEVEL_WIDTH-1:0] root
);
  import ant_pkg::*;

  localparam int STEP_WIDTH = $clog2(LEVEL_WIDTH + 1);

  logic [SQ_WIDTH-1:0]      rad;
  logic [LEVEL_WIDTH+1:0]   rem;
  logic [LEVEL_WIDTH-1:0]   res;
  logic [STEP_WIDTH-1:0]    steps;
  logic                     busy;
  logic [LEVEL_WIDTH+1:0]   shifted;
  logic [LEVEL_WIDTH+1:0]   trial;
  logic                     fits;

  // Bring down the next two radicand bits and test 4*root + 1.
  always_comb begin
    shifted = {rem[LEVEL_WIDTH-1:0], rad[SQ_WIDTH-1:SQ_WIDTH-2]};
    trial   = {res, 2'b01};
    fits    = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_WIDTH'(LEVEL_WIDTH);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= {rad[SQ_WIDTH-3:0], 2'b00};
      rem <= fits ? (shifted - trial) : shifted;
      res <= {res[LEVEL_WIDTH-2:0], fits};
    end
  end

  assign root = res;

endmodule

`default_nettype wire

/* hw/rtl/adaptive_noise_threshold.sv */
// Adaptive noise threshold: windowed mean and deviation with k-sigma thresholds.
// When fewer than two ring entries are filled, the scan, divisions and square root are
// skipped, and the held mean and deviation are used for the thresholds.
// The ring scan reads one entry per cycle, then two 40-step serial divisions and a
// 16-step serial square root follow. A new item is accepted once the result is registered.
// Reset is synchronous; the level ring is not cleared and needs no clearing pass.
`default_nettype none

module adaptive_noise_threshold (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ant_pkg::LEVEL_WIDTH-1:0] noise_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ant_pkg::LEVEL_WIDTH-1:0] mean_level,
  output logic [ant_pkg::LEVEL_WIDTH-1:0] std_dev_level,
  output logic [ant_pkg::LEVEL_WIDTH-1:0] onset_threshold,
  output logic [ant_pkg::LEVEL_WIDTH-1:0] silence_threshold,
  output logic                            ready_res,
  input  logic                            cfg_we,
  input  logic [ant_pkg::IDX_WIDTH-1:0]   cfg_index,
  input  logic [ant_pkg::CFG_WIDTH-1:0]   cfg_data
);
  import ant_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_DIVM  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_VSUM  = 4'd7;
  localparam logic [3:0] S_DIVV  = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_THR1  = 4'd10;
  localparam logic [3:0] S_THR2  = 4'd11;

  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX  = {LEVEL_WIDTH{1'b1}};
  localparam logic [THR_WIDTH-1:0]   ROUND_HALF = THR_WIDTH'(1 << (FRAC_BITS - 1));

  // Configuration registers.
  logic [HIST_WIDTH-1:0]  history_length;
  logic [SIGMA_WIDTH-1:0] onset_sigma;
  logic [SIGMA_WIDTH-1:0] silence_sigma;
  logic [LEVEL_WIDTH-1:0] min_std_dev;

  // Ring state and tracked statistics.
  logic [LEVEL_WIDTH-1:0] level_store [MAX_HISTORY];
  logic [POS_WIDTH-1:0]   write_position;
  logic                   ring_full;
  logic [LEVEL_WIDTH-1:0] mean_reg;
  logic [LEVEL_WIDTH-1:0] deviation_reg;

  // Sequencer and datapath registers.
  logic [3:0]             state;
  logic [CNT_WIDTH-1:0]   count;
  logic [POS_WIDTH-1:0]   rd_index;
  logic [LEVEL_WIDTH-1:0] rd_data;
  logic                   rd_valid;
  logic [SQ_WIDTH-1:0]    square;
  logic                   sq_valid;
  logic [SUM_WIDTH-1:0]   sum;
  logic [VSUM_WIDTH-1:0]  sum_sq;
  logic [LEVEL_WIDTH-1:0] mean_calc;
  logic [MS_WIDTH-1:0]    mean_sum;
  logic [SQ_WIDTH-1:0]    mean_sq;
  logic [VSUM_WIDTH-1:0]  count_mean_sq;
  logic [PROD_WIDTH-1:0]  onset_prod;
  logic [PROD_WIDTH-1:0]  silence_prod;

  // Combinational helpers.
  logic [CNT_WIDTH-1:0]   len;
  logic [CNT_WIDTH-1:0]   count_next;
  logic [POS_WIDTH-1:0]   wr_pos;
  logic                   full_pre;
  logic [CNT_WIDTH-1:0]   pos_inc;
  logic [POS_WIDTH-1:0]   write_position_next;
  logic                   ring_full_next;
  logic                   accept;
  logic                   drained;
  logic                   out_free;
  logic [DIV_WIDTH+1:0]   vsum_wide;
  logic                   div_start;
  logic [DIV_WIDTH-1:0]   div_dividend;
  logic                   div_done;
  logic [DIV_WIDTH-1:0]   div_quotient;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [LEVEL_WIDTH-1:0] sqrt_root;
  logic [LEVEL_WIDTH-1:0] dev_floored;
  logic                   ready_flag;

  // Mean plus the rounded Q4.8 multiple of the deviation, saturated to the level range.
  function automatic logic [LEVEL_WIDTH-1:0] sat_threshold(
    input logic [LEVEL_WIDTH-1:0] mean_in,
    input logic [PROD_WIDTH-1:0]  prod_in
  );
    logic [THR_WIDTH-1:0] total;
    total = THR_WIDTH'(mean_in) + ((THR_WIDTH'(prod_in) + ROUND_HALF) >> FRAC_BITS);
    if (total > THR_WIDTH'(LEVEL_MAX)) begin
      return LEVEL_MAX;
    end
    return total[LEVEL_WIDTH-1:0];
  endfunction

  // Effective window length, held to the supported range.
  always_comb begin
    if (history_length < HIST_WIDTH'(MIN_LENGTH)) begin
      len = CNT_WIDTH'(MIN_LENGTH);
    end else if (CNT_WIDTH'(history_length) > CNT_WIDTH'(MAX_HISTORY)) begin
      len = CNT_WIDTH'(MAX_HISTORY);
    end else begin
      len = CNT_WIDTH'(history_length);
    end
  end

  // Ring pointer update for an accepted item.
  always_comb begin
    full_pre = ring_full;
    wr_pos   = write_position;
    if (CNT_WIDTH'(write_position) >= len) begin
      wr_pos   = '0;
      full_pre = 1'b1;
    end
    pos_inc             = CNT_WIDTH'(wr_pos) + 1'b1;
    write_position_next = pos_inc[POS_WIDTH-1:0];
    ring_full_next      = full_pre;
    if (pos_inc >= len) begin
      write_position_next = '0;
      ring_full_next      = 1'b1;
    end
  end

  // Handshake and sequencing conditions.
  always_comb begin
    in_ready     = (state == S_IDLE);
    accept       = in_valid && in_ready;
    out_free     = !out_valid || out_ready;
    drained      = !rd_valid && !sq_valid;
    count_next   = ring_full ? len : CNT_WIDTH'(write_position);
    vsum_wide    = (DIV_WIDTH + 2)'(sum_sq) + (DIV_WIDTH + 2)'(count_mean_sq)
                   - ((DIV_WIDTH + 2)'(mean_sum) << 1);
    div_start    = ((state == S_DRAIN) && drained) || (state == S_VSUM);
    div_dividend = (state == S_VSUM) ? vsum_wide[DIV_WIDTH-1:0]
                   : (DIV_WIDTH'(sum) + DIV_WIDTH'(count >> 1));
    sqrt_start   = (state == S_DIVV) && div_done;
    dev_floored  = (sqrt_root < min_std_dev) ? min_std_dev : sqrt_root;
    ready_flag   = ring_full || (CNT_WIDTH'(write_position) > (len >> 1));
  end

  // Level ring: one write port for arriving items, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      level_store[wr_pos] <= noise_level;
    end
    rd_data <= level_store[rd_index];
  end

  // Configuration registers and ring pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      history_length <= HISTORY_LENGTH_RESET;
      onset_sigma    <= ONSET_SIGMA_RESET;
      silence_sigma  <= SILENCE_SIGMA_RESET;
      min_std_dev    <= MIN_STD_DEV_RESET;
      write_position <= '0;
      ring_full      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HISTORY_LENGTH: begin
          history_length <= cfg_data[HIST_WIDTH-1:0];
          write_position <= '0;
          ring_full      <= 1'b0;
        end
        REG_ONSET_SIGMA:   onset_sigma   <= cfg_data[SIGMA_WIDTH-1:0];
        REG_SILENCE_SIGMA: silence_sigma <= cfg_data[SIGMA_WIDTH-1:0];
        REG_MIN_STD_DEV:   min_std_dev   <= cfg_data[LEVEL_WIDTH-1:0];
        default: ;
      endcase
    end else if (accept) begin
      write_position <= write_position_next;
      ring_full      <= ring_full_next;
    end
  end

  // Sequencer: scan, mean division, variance assembly, division, square root, thresholds.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_valid      <= 1'b0;
      sq_valid      <= 1'b0;
      mean_reg      <= '0;
      deviation_reg <= '0;
      out_valid     <= 1'b0;
    end else begin
      rd_valid <= (state == S_SUM);
      sq_valid <= rd_valid;
      // A taken result leaves unless the next one is loaded in the same cycle.
      if (out_valid && out_ready && (state != S_THR2)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          count    <= count_next;
          rd_index <= '0;
          if (count_next < CNT_WIDTH'(2)) begin
            state <= S_THR1;
          end else begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          rd_index <= rd_index + 1'b1;
          if (CNT_WIDTH'(rd_index) == count - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drained) begin
            state <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (div_done) begin
            mean_calc <= div_quotient[LEVEL_WIDTH-1:0];
            state     <= S_MUL1;
          end
        end
        S_MUL1: begin
          mean_sum <= mean_calc * sum;
          mean_sq  <= mean_calc * mean_calc;
          state    <= S_MUL2;
        end
        S_MUL2: begin
          count_mean_sq <= count * mean_sq;
          state         <= S_VSUM;
        end
        S_VSUM: begin
          state <= S_DIVV;
        end
        S_DIVV: begin
          if (div_done) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            mean_reg      <= mean_calc;
            deviation_reg <= dev_floored;
            state         <= S_THR1;
          end
        end
        S_THR1: begin
          onset_prod   <= onset_sigma * deviation_reg;
          silence_prod <= silence_sigma * deviation_reg;
          state        <= S_THR2;
        end
        S_THR2: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            mean_level        <= mean_reg;
            std_dev_level     <= deviation_reg;
            onset_threshold   <= sat_threshold(mean_reg, onset_prod);
            silence_threshold <= sat_threshold(mean_reg, silence_prod);
            ready_res         <= ready_flag;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Scan accumulators: sum of levels and sum of squared levels.
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      sum    <= '0;
      sum_sq <= '0;
    end else begin
      if (rd_valid) begin
        sum <= sum + SUM_WIDTH'(rd_data);
      end
      if (sq_valid) begin
        sum_sq <= sum_sq + VSUM_WIDTH'(square);
      end
    end
    square <= rd_data * rd_data;
  end

  // Shared serial divider for the mean and the variance.
  ant_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Serial square root of the variance.
  ant_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (div_quotient[SQ_WIDTH-1:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

endmodule

`default_nettype wire

/* tb/adaptive_noise_threshold_tb.sv */
// Self-checking testbench for the adaptive noise threshold block.
`timescale 1ns / 100ps

module adaptive_noise_threshold_tb;
  import ant_pkg::*;

  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SEGMENTS      = 10;
  localparam int SEGMENT_ITEMS = 115;

  // One result of the block, as the tracker predicts it.
  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] mean_lvl;
    logic [LEVEL_WIDTH-1:0] dev_lvl;
    logic [LEVEL_WIDTH-1:0] onset_lvl;
    logic [LEVEL_WIDTH-1:0] silence_lvl;
    logic                   ready_flag;
  } threshold_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [LEVEL_WIDTH-1:0] noise_level = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [LEVEL_WIDTH-1:0] mean_level;
  logic [LEVEL_WIDTH-1:0] std_dev_level;
  logic [LEVEL_WIDTH-1:0] onset_threshold;
  logic [LEVEL_WIDTH-1:0] silence_threshold;
  logic                   ready_res;
  logic                   cfg_we = 1'b0;
  logic [IDX_WIDTH-1:0]   cfg_index = '0;
  logic [CFG_WIDTH-1:0]   cfg_data = '0;

  adaptive_noise_threshold dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .noise_level      (noise_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mean_level       (mean_level),
    .std_dev_level    (std_dev_level),
    .onset_threshold  (onset_threshold),
    .silence_threshold(silence_threshold),
    .ready_res        (ready_res),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Free-running clock, 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Tracker state: the level ring, fill position and the held statistics.
  logic [LEVEL_WIDTH-1:0]   level_ring [MAX_HISTORY];
  int unsigned              ring_pos = 0;
  bit                       ring_wrapped = 1'b0;
  logic [LEVEL_WIDTH-1:0]   mean_est = '0;
  logic [LEVEL_WIDTH-1:0]   dev_est = '0;
  logic [HIST_WIDTH-1:0]    window_reg = HISTORY_LENGTH_RESET;
  logic [SIGMA_WIDTH-1:0]   onset_k = ONSET_SIGMA_RESET;
  logic [SIGMA_WIDTH-1:0]   silence_k = SILENCE_SIGMA_RESET;
  logic [LEVEL_WIDTH-1:0]   dev_floor = MIN_STD_DEV_RESET;

  threshold_result_t expected_results [$];
  threshold_result_t seen_result;
  threshold_result_t want_result;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          reg_writes = 0;
  int          error_count = 0;

  // Window length in use: the register clamped to the ring's legal range.
  function automatic int unsigned window_len();
    int unsigned n;
    n = window_reg;
    if (n < MIN_LENGTH) n = MIN_LENGTH;
    if (n > MAX_HISTORY) n = MAX_HISTORY;
    return n;
  endfunction

  // Integer square root, rounded down, built one result bit at a time.
  function automatic logic [LEVEL_WIDTH-1:0] floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = LEVEL_WIDTH - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[LEVEL_WIDTH-1:0];
  endfunction

  // Mean plus a Q4.8 multiple of the deviation, rounded and saturated.
  function automatic logic [LEVEL_WIDTH-1:0] sigma_threshold(input logic [SIGMA_WIDTH-1:0] k);
    longint unsigned kk;
    longint unsigned dd;
    longint unsigned t;
    kk = k;
    dd = dev_est;
    t = mean_est + ((kk * dd + 128) >> FRAC_BITS);
    if (t > (64'd1 << LEVEL_WIDTH) - 1) t = (64'd1 << LEVEL_WIDTH) - 1;
    return t[LEVEL_WIDTH-1:0];
  endfunction

  // Store one level, refresh the statistics and form the expected result.
  function automatic threshold_result_t track_level(input logic [LEVEL_WIDTH-1:0] lvl);
    int unsigned       len;
    int unsigned       count;
    longint unsigned   total;
    longint unsigned   spread;
    longint unsigned   centre;
    longint unsigned   x;
    longint unsigned   diff;
    longint unsigned   root;
    threshold_result_t r;
    len = window_len();
    if (ring_pos >= len) begin
      ring_pos = 0;
      ring_wrapped = 1'b1;
    end
    level_ring[ring_pos] = lvl;
    ring_pos++;
    if (ring_pos >= len) begin
      ring_pos = 0;
      ring_wrapped = 1'b1;
    end
    count = ring_wrapped ? len : ring_pos;
    // With fewer than two entries the held mean and deviation stand.
    if (count >= 2) begin
      total = 0;
      for (int i = 0; i < count; i++) total += level_ring[i];
      centre = (total + count / 2) / count;
      spread = 0;
      for (int i = 0; i < count; i++) begin
        x = level_ring[i];
        diff = (x >= centre) ? x - centre : centre - x;
        spread += diff * diff;
      end
      root = floor_sqrt(spread / count);
      if (root < dev_floor) root = dev_floor;
      mean_est = centre[LEVEL_WIDTH-1:0];
      dev_est = root[LEVEL_WIDTH-1:0];
    end
    r.mean_lvl = mean_est;
    r.dev_lvl = dev_est;
    r.onset_lvl = sigma_threshold(onset_k);
    r.silence_lvl = sigma_threshold(silence_k);
    r.ready_flag = ring_wrapped || (ring_pos > len / 2);
    return r;
  endfunction

  // Noise-like levels: many near a base, others spread, extremes and small values.
  function automatic logic [LEVEL_WIDTH-1:0] pick_level(input int unsigned noise_base);
    int unsigned sel;
    int unsigned v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = noise_base + $urandom_range(400);
      if (v > 65535) v = 65535;
    end else if (sel < 70) begin
      v = $urandom_range(65535);
    end else if (sel < 85) begin
      v = $urandom_range(1) ? 65535 : 0;
    end else begin
      v = $urandom_range(255);
    end
    return v[LEVEL_WIDTH-1:0];
  endfunction

  function automatic logic [SIGMA_WIDTH-1:0] pick_sigma();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 2) return '0;
    if (sel < 4) return '1;
    return SIGMA_WIDTH'($urandom_range(4095));
  endfunction

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_result.mean_lvl = mean_level;
      seen_result.dev_lvl = std_dev_level;
      seen_result.onset_lvl = onset_threshold;
      seen_result.silence_lvl = silence_threshold;
      seen_result.ready_flag = ready_res;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: result with nothing expected: mean %0d dev %0d", mean_level,
                   std_dev_level);
      end else begin
        want_result = expected_results.pop_front();
        results_checked++;
        if (seen_result.mean_lvl !== want_result.mean_lvl ||
            seen_result.dev_lvl !== want_result.dev_lvl ||
            seen_result.onset_lvl !== want_result.onset_lvl ||
            seen_result.silence_lvl !== want_result.silence_lvl ||
            seen_result.ready_flag !== want_result.ready_flag) begin
          error_count++;
          if (error_count <= 10)
            $display({"ERROR: result %0d: expected mean %0d dev %0d onset %0d ",
                      "silence %0d ready %0b, got mean %0d dev %0d onset %0d ",
                      "silence %0d ready %0b"},
                     results_checked, want_result.mean_lvl, want_result.dev_lvl,
                     want_result.onset_lvl, want_result.silence_lvl, want_result.ready_flag,
                     seen_result.mean_lvl, seen_result.dev_lvl, seen_result.onset_lvl,
                     seen_result.silence_lvl, seen_result.ready_flag);
        end
      end
    end
  end

  // Offer one level, with a random gap first, and record its expected result.
  task automatic send_level(input logic [LEVEL_WIDTH-1:0] lvl);
    threshold_result_t r;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    noise_level <= lvl;
    do @(posedge clk); while (!in_ready);
    r = track_level(lvl);
    expected_results = {expected_results, r};
    items_sent++;
  endtask

  // Stop offering and wait until every expected result has come back or the wait limit runs out.
  task automatic wait_results_done(input int settle);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  // One register write; the tracker applies the same masking and side effects.
  task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_HISTORY_LENGTH: begin
        window_reg = data[HIST_WIDTH-1:0];
        ring_pos = 0;
        ring_wrapped = 1'b0;
      end
      REG_ONSET_SIGMA:   onset_k = data[SIGMA_WIDTH-1:0];
      REG_SILENCE_SIGMA: silence_k = data[SIGMA_WIDTH-1:0];
      REG_MIN_STD_DEV:   dev_floor = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Reset values: first item holds zero statistics, later ones start tracking.
  task automatic test_reset_defaults();
    send_level(16'h0000);
    send_level(16'hFFFF);
    send_level(16'hFFFF);
    send_level(16'h0000);
    wait_results_done(4);
  endtask

  // Register extremes: shortest window, saturating thresholds, zero deviation.
  task automatic test_register_extremes();
    write_reg(REG_HISTORY_LENGTH, 16'd0);
    write_reg(REG_ONSET_SIGMA, 16'd4095);
    write_reg(REG_SILENCE_SIGMA, 16'd0);
    write_reg(REG_MIN_STD_DEV, 16'hFFFF);
    // Twelve items wrap the ten-entry ring and set the full flag.
    for (int i = 0; i < 12; i++)
      send_level(i[0] ? 16'hFFFF : (i < 6 ? 16'h0000 : 16'h5555));
    wait_results_done(4);
    // Flat input with no floor gives a deviation of zero.
    write_reg(REG_HISTORY_LENGTH, 16'd9);
    write_reg(REG_MIN_STD_DEV, 16'd0);
    write_reg(REG_ONSET_SIGMA, 16'd1);
    write_reg(REG_SILENCE_SIGMA, 16'd4095);
    for (int i = 0; i < 4; i++) send_level(16'd1234);
    wait_results_done(4);
  endtask

  // Long output hold-off while items keep coming, so the input stalls.
  task automatic test_output_hold();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    write_reg(REG_HISTORY_LENGTH, 16'd16);
    write_reg(REG_MIN_STD_DEV, 16'd7);
    hold_requests++;
    for (int i = 0; i < 20; i++) send_level(pick_level(16'h0800));
    wait_results_done(4);
  endtask

  // Random windows and multipliers across the idling modes.
  task automatic test_random_windows();
    int unsigned lengths [SEGMENTS];
    int unsigned noise_base;
    int unsigned floor_sel;
    int unsigned floor_val;
    lengths = '{10, 128, 0, 255, 9, 129, 37, 64, 200, 11};
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      // Some segments keep the ring running across the other register writes.
      if (seg != 3 && seg != 7)
        write_reg(REG_HISTORY_LENGTH,
                  CFG_WIDTH'(($urandom_range(255) << HIST_WIDTH) | lengths[seg]));
      write_reg(REG_ONSET_SIGMA,
                CFG_WIDTH'(($urandom_range(15) << SIGMA_WIDTH) | pick_sigma()));
      write_reg(REG_SILENCE_SIGMA,
                CFG_WIDTH'(($urandom_range(15) << SIGMA_WIDTH) | pick_sigma()));
      floor_sel = $urandom_range(9);
      if (floor_sel == 0) floor_val = 0;
      else if (floor_sel == 1) floor_val = 65535;
      else if (floor_sel == 2) floor_val = $urandom_range(65535);
      else floor_val = $urandom_range(64);
      write_reg(REG_MIN_STD_DEV, CFG_WIDTH'(floor_val));
      noise_base = $urandom_range(65535);
      for (int i = 0; i < SEGMENT_ITEMS; i++) send_level(pick_level(noise_base));
      wait_results_done(4);
    end
  endtask

  // Sequence of tests and the final verdict.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_output_hold();
    test_random_windows();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    wait_results_done(SETTLE_CYCLES);
    if (expected_results.size() != 0) begin
      $display("ERROR: %0d results never arrived", expected_results.size());
      error_count += expected_results.size();
    end
    $display("Run covered %0d noise levels and %0d register writes over window lengths 0..255,",
             items_sent, reg_writes);
    $display("with %0d results compared and %0d errors found.", results_checked, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ant_pkg.sv
hw/rtl/ant_div.sv
hw/rtl/ant_sqrt.sv
hw/rtl/adaptive_noise_threshold.sv
tb/adaptive_noise_threshold_tb.sv
